[sv/sharpen_3x3_stream_top_assert.svh]
// Assertion macros for the 3x3 sharpen stream block.
// Depends on a clock named clk and a synchronous reset named rst in the including scope.
`ifndef SHARPEN_3X3_STREAM_TOP_ASSERT_SVH
`define SHARPEN_3X3_STREAM_TOP_ASSERT_SVH

// Checks an implication property on every clock edge outside reset.
`define SH3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks an implication property with no reset qualifier.
`define SH3_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/sh3_pkg.sv]
// Shared types and constants for the 3x3 sharpen stream block.
// No dependencies.
package sh3_pkg;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  localparam int PIX_W     = 8;
  localparam int ROW_W     = 12;
  localparam int COL_W     = 10;
  localparam int FW_W      = 11;
  localparam int FH_W      = 13;
  localparam int MIN_DIM   = 3;
  localparam int FW_RESET  = 640;
  localparam int FH_RESET  = 480;
  localparam int CENTRE_K  = 5;

  // One output word.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             fend;
  } result_t;

endpackage

[sv/sh3_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sh3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/sharpen_3x3_stream_top.sv]
// Top level of the streaming 3x3 Laplacian sharpen block.
// Depends on sh3_pkg, sh3_ram and sharpen_3x3_stream_top_assert.svh.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata (frame_width/height)
//  input    | in_valid/in_ready    | pixel_in
//  output   | out_valid/out_ready  | pixel_out, out_row, out_col, run_last,
//           |                      | frame_end
//
// One input word per clock while the output is ready; a word passes the compute stage
// and then the output register. Rows other than the last give at most one word per
// input, so the block runs at one pixel per clock; each input of the last row gives
// two words, so that row is limited by the output port's one word per clock.
// Reset and any config write return the frame position to the top-left pixel.
// A stall on the output holds the compute stage and then the input side.

`include "sharpen_3x3_stream_top_assert.svh"

module sharpen_3x3_stream_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // Input pixel stream.
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sh3_pkg::PIX_W-1:0]  pixel_in,
  // Output pixel stream.
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sh3_pkg::PIX_W-1:0]  pixel_out,
  output logic [sh3_pkg::ROW_W-1:0]  out_row,
  output logic [sh3_pkg::COL_W-1:0]  out_col,
  output logic                       run_last,
  output logic                       frame_end
);

  import sh3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RB = $clog2(MAX_HEIGHT);
  localparam int EW = 2 * PIX_W;

  // Configuration registers.
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic            cfg_wr;
  reg_idx_t        cfg_idx;

  // Frame position of the next input word.
  logic [AW-1:0] col;
  logic [RB-1:0] row;

  // Compute stage.
  logic             s2_valid;
  logic [PIX_W-1:0] s2_pix;
  logic [AW-1:0]    s2_col;
  logic [RB-1:0]    s2_row;
  logic             s2_go;
  logic [EW-1:0]    cur_entry;
  logic [PIX_W-1:0] left;

  // Output stage.
  result_t     slot0;
  result_t     slot1;
  logic [1:0]  o_cnt;
  logic        out_pop;
  logic        out_free;

  // Memory ports.
  logic          mem_wr;
  logic [AW-1:0] mem_wr_addr;
  logic [EW-1:0] mem_wr_data;
  logic          mem_rd;
  logic [AW-1:0] mem_rd_addr;
  logic [EW-1:0] mem_rd_data;

  logic          in_accept;
  logic [31:0]   w_eff;
  logic [31:0]   h_eff;
  logic [AW-1:0] w_last;
  logic [RB-1:0] h_last;

  // Datapath of the compute stage.
  logic [PIX_W-1:0]  centre;
  logic [PIX_W-1:0]  up;
  logic [PIX_W-1:0]  right;
  logic [10:0]       five_c;
  logic signed [11:0] lap;
  logic [PIX_W-1:0]  lap_sat;
  logic              interior;
  logic              has_a;
  logic              has_b;
  result_t           res_a;
  result_t           res_b;
  logic [31:0]       row_a32;
  logic [31:0]       row_b32;
  logic [31:0]       col32;

  // Configuration port: always ready, write on the access cycle.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(FW_RESET);
      frame_height <= FH_W'(FH_RESET);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // Effective frame size, clamped to the supported range.
  always_comb begin
    if (32'(frame_width) < 32'(MIN_DIM)) begin
      w_eff = 32'(MIN_DIM);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end else begin
      w_eff = 32'(frame_width);
    end
    if (32'(frame_height) < 32'(MIN_DIM)) begin
      h_eff = 32'(MIN_DIM);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h_eff = 32'(MAX_HEIGHT);
    end else begin
      h_eff = 32'(frame_height);
    end
  end

  assign w_last = AW'(w_eff - 32'd1);
  assign h_last = RB'(h_eff - 32'd1);

  // Handshakes between input, compute stage and output register.
  assign out_valid = (o_cnt != 2'd0);
  assign out_pop   = out_valid & out_ready;
  assign out_free  = (o_cnt == 2'd0) || ((o_cnt == 2'd1) && out_ready);
  assign s2_go     = s2_valid & out_free;
  assign in_ready  = ~s2_valid | s2_go;
  assign in_accept = in_valid & in_ready;

  // Frame position counters.
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col <= '0;
      row <= '0;
    end else if (in_accept) begin
      if (col == w_last) begin
        col <= '0;
        row <= (row == h_last) ? '0 : row + RB'(1);
      end else begin
        col <= col + AW'(1);
      end
    end
  end

  // The read fetches the column to the right; it becomes the next centre entry.
  assign mem_rd      = in_accept;
  assign mem_rd_addr = (col == w_last) ? '0 : col + AW'(1);

  // Compute stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (in_ready) begin
      s2_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s2_pix <= pixel_in;
      s2_col <= col;
      s2_row <= row;
    end
  end

  // Stored column entry of the current item and the left neighbor.
  always_ff @(posedge clk) begin
    if (s2_go) begin
      cur_entry <= mem_rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      left <= '0;
    end else if (s2_go) begin
      left <= (s2_col == w_last) ? '0 : centre;
    end
  end

  // Laplacian kernel and saturation.
  assign centre = cur_entry[PIX_W-1:0];
  assign up     = cur_entry[EW-1:PIX_W];
  assign right  = (s2_col == w_last) ? '0 : mem_rd_data[PIX_W-1:0];
  assign five_c = (11'(centre) << 2) + 11'(centre);

  always_comb begin
    lap = $signed({1'b0, five_c}) - $signed(12'(left)) - $signed(12'(right))
        - $signed(12'(up)) - $signed(12'(s2_pix));
    if (lap < 12'sd0) begin
      lap_sat = '0;
    end else if (lap > 12'sd255) begin
      lap_sat = '1;
    end else begin
      lap_sat = lap[PIX_W-1:0];
    end
  end

  // Output words for the current item.
  assign interior = (s2_row != RB'(1)) && (s2_col != '0) && (s2_col != w_last);
  assign has_a    = (s2_row != '0);
  assign has_b    = (s2_row == h_last);
  assign row_a32  = 32'(s2_row - RB'(1));
  assign row_b32  = 32'(s2_row);
  assign col32    = 32'(s2_col);

  always_comb begin
    res_a.pixel = interior ? lap_sat : '0;
    res_a.row   = row_a32[ROW_W-1:0];
    res_a.col   = col32[COL_W-1:0];
    res_a.last  = ~has_b;
    res_a.fend  = 1'b0;
    res_b.pixel = '0;
    res_b.row   = row_b32[ROW_W-1:0];
    res_b.col   = col32[COL_W-1:0];
    res_b.last  = 1'b1;
    res_b.fend  = (s2_col == w_last);
  end

  // Write back the column: the old centre moves up, the new pixel becomes centre.
  assign mem_wr      = s2_go;
  assign mem_wr_addr = s2_col;
  assign mem_wr_data = {centre, s2_pix};

  sh3_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register holding up to two words.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_cnt <= 2'd0;
    end else if (s2_go) begin
      o_cnt <= 2'(has_a) + 2'(has_b);
    end else if (out_pop) begin
      o_cnt <= (o_cnt == 2'd2) ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      slot0 <= res_a;
      slot1 <= res_b;
    end else if (out_pop && (o_cnt == 2'd2)) begin
      slot0 <= slot1;
    end
  end

  assign pixel_out = slot0.pixel;
  assign out_row   = slot0.row;
  assign out_col   = slot0.col;
  assign run_last  = slot0.last;
  assign frame_end = slot0.fend;

  // The read ahead and the write back never touch the same column.
  `SH3_ASSERT(a_no_rw_clash, (mem_wr && mem_rd) |-> (mem_wr_addr != mem_rd_addr),
              "line store read and write hit the same column")
  // A stalled compute stage keeps its fetched column.
  `SH3_ASSERT(a_fetch_held, (s2_valid && !s2_go) |=> $stable(mem_rd_data),
              "fetched column changed while the compute stage stalled")
  // A word that is not the last of its item is followed by its partner.
  `SH3_ASSERT(a_pair_follows, (out_pop && !run_last) |=> (out_valid && run_last
              && (out_col == $past(out_col))), "second word of a pair missing")
  // The frame end marks the final word of an item.
  `SH3_ASSERT(a_fend_last, (out_valid && frame_end) |-> run_last,
              "frame end on a word that is not last")
  // Outside reset the output register never claims more than two words.
  `SH3_ASSERT_ALWAYS(a_cnt_range, !rst |-> (o_cnt != 2'd3), "output word count out of range")

endmodule
